// ===== hw/rtl/aetp_pkg.sv =====
package aetp_pkg;

    // Parameter store geometry
    localparam int MaxParameters = 10;
    localparam int IdxW = $clog2(MaxParameters);
    localparam int CntW = $clog2(MaxParameters + 1);

    // Reset values of the screen registers
    localparam logic [7:0] ResetColumns = 8'd80;
    localparam logic [7:0] ResetRows    = 8'd25;

    // Configuration register indexes
    localparam logic CFG_COLUMNS = 1'b0;
    localparam logic CFG_ROWS    = 1'b1;

    // Output command codes
    localparam logic [1:0] CMD_PUT_CHAR  = 2'd0;
    localparam logic [1:0] CMD_CLEAR_SCR = 2'd1;
    localparam logic [1:0] CMD_CLEAR_EOL = 2'd2;
    localparam logic [1:0] CMD_SET_COLOR = 2'd3;

    // Default colours
    localparam logic [4:0] DefaultFg = 5'd7;
    localparam logic [2:0] DefaultBg = 3'd0;

    // Control from the sequencer to the colour unit
    typedef struct packed {
        logic            start;
        logic            defaults;
        logic [CntW-1:0] count;
    } t_sgr_ctrl;

    // Status from the colour unit
    typedef struct packed {
        logic            busy;
        logic [IdxW-1:0] idx;
        logic [4:0]      fg;
        logic [2:0]      bg;
    } t_sgr_stat;

    // ANSI colour number to DOS colour number
    function automatic logic [2:0] dos_map(input logic [2:0] v);
        logic [2:0] r;
        unique case (v)
            3'd0: r = 3'd0;
            3'd1: r = 3'd4;
            3'd2: r = 3'd2;
            3'd3: r = 3'd6;
            3'd4: r = 3'd1;
            3'd5: r = 3'd5;
            3'd6: r = 3'd3;
            default: r = 3'd7;
        endcase
        return r;
    endfunction

    // Clamp a coordinate to 1..lim
    function automatic logic [7:0] clamp_lim(input logic [7:0] v, input logic [7:0] lim);
        logic [7:0] r;
        if (v == 8'd0) r = 8'd1;
        else if (v > lim) r = lim;
        else r = v;
        return r;
    endfunction

endpackage

// ===== hw/rtl/aetp_if.sv =====
interface aetp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

interface aetp_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] char_code;
    logic [7:0] column;
    logic [7:0] row;
    logic [4:0] foreground;
    logic [2:0] background;

    modport source (output valid, output command, output char_code, output column,
                    output row, output foreground, output background, input ready);
    modport sink (input valid, input command, input char_code, input column,
                  input row, input foreground, input background, output ready);
endinterface

// ===== hw/rtl/ansi_escape_terminal_parser_core.sv =====
// ANSI/VT100 escape sequence parser.
// Input channel i_byte carries one byte of the terminal stream per
// transaction; output channel o_cmd carries at most one drawing command per
// byte (put character, clear screen, clear to end of line, set colour)
// together with the cursor position and colours where it applies.
// Screen size is written through i_cfg_we / i_cfg_index / i_cfg_data; the
// user is to write it only while the block is idle (the block itself does not
// enforce this): index 0 is the column count, index 1 the row count.
// An accepted byte's command, if any, is registered in the output stage the
// cycle after; for the SGR final byte 'm' it follows a walk of the stored
// parameters (up to 10) through the shared colour unit, one per cycle.
// Bytes other than 'm' need no walk before their output transaction.
// i_byte.ready is low while a command waits in the output stage or the
// colour walk runs, so a stalled receiver holds the input back.
// Synchronous reset: text phase, cursor and saved cursor at (1,1),
// foreground 7, background 0, wrap on, screen 80 by 25.
module ansi_escape_terminal_parser_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    aetp_byte_if.sink  i_byte,
    aetp_cmd_if.source o_cmd,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    localparam logic [1:0] PH_TEXT    = 2'd0;
    localparam logic [1:0] PH_BRACKET = 2'd1;
    localparam logic [1:0] PH_PARAMS  = 2'd2;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;

    localparam int Max = aetp_pkg::MaxParameters;
    localparam int CW  = aetp_pkg::CntW;

    logic [7:0]    r_cols, r_rows;
    logic [1:0]    r_phase, n_phase;
    logic          r_st, n_st;
    logic [7:0]    r_store [Max];
    logic [7:0]    r_acc, n_acc;
    logic [CW-1:0] r_pc, n_pc;
    logic [1:0]    r_dc, n_dc;
    logic          r_ads, n_ads;
    logic          r_fpi, n_fpi;
    logic [7:0]    r_col, n_col, r_row, n_row;
    logic [7:0]    r_scol, n_scol, r_srow, n_srow;
    logic          r_wrap, n_wrap;
    logic          r_ov;
    logic [1:0]    r_ocmd;
    logic [7:0]    r_ochar, r_ocol, r_orow;
    logic [4:0]    r_ofg;
    logic [2:0]    r_obg;

    logic                emit;
    logic [1:0]          emit_cmd;
    logic [7:0]          emit_char;
    logic                clr_store, wr_store;
    logic                accept;
    logic [7:0]          c, mc, mr, a, s1;
    logic [CW-1:0]       p;
    logic                is_digit;
    aetp_pkg::t_sgr_ctrl sgr_ctrl;
    aetp_pkg::t_sgr_stat sgr_stat;

    assign i_byte.ready = (r_st == ST_IDLE) && !r_ov;
    assign accept       = i_byte.valid && i_byte.ready;
    assign c            = i_byte.data_byte;
    assign mc           = (r_cols == 8'd0) ? 8'd1 : r_cols;
    assign mr           = (r_rows == 8'd0) ? 8'd1 : r_rows;
    assign a            = r_store[0];
    assign s1           = r_store[1];
    assign is_digit     = (c >= 8'h30) && (c <= 8'h39);
    assign p            = r_pc + CW'((r_ads && r_pc < CW'(Max)) ? 1 : 0);

    aetp_sgr_unit u_sgr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (sgr_ctrl),
        .i_value (r_store[sgr_stat.idx]),
        .o_stat  (sgr_stat)
    );

    // Decode the accepted byte, or finish the colour walk
    always_comb begin
        n_phase   = r_phase;
        n_st      = r_st;
        n_acc     = r_acc;
        n_pc      = r_pc;
        n_dc      = r_dc;
        n_ads     = r_ads;
        n_fpi     = r_fpi;
        n_col     = r_col;
        n_row     = r_row;
        n_scol    = r_scol;
        n_srow    = r_srow;
        n_wrap    = r_wrap;
        emit      = 1'b0;
        emit_cmd  = aetp_pkg::CMD_PUT_CHAR;
        emit_char = 8'd0;
        clr_store = 1'b0;
        wr_store  = 1'b0;
        sgr_ctrl  = '{start: 1'b0, defaults: 1'b0, count: p};
        if (r_st == ST_WALK) begin
            if (!sgr_stat.busy) begin
                emit     = 1'b1;
                emit_cmd = aetp_pkg::CMD_SET_COLOR;
                n_st     = ST_IDLE;
            end
        end else if (accept) begin
            unique case (r_phase)
                PH_BRACKET: n_phase = PH_PARAMS;
                PH_PARAMS: begin
                    if (is_digit && r_dc < 2'd3) begin
                        // accumulate as v*10+d modulo 256
                        if (r_dc == 2'd0) n_acc = c - 8'h30;
                        else n_acc = (r_acc << 3) + (r_acc << 1) + (c - 8'h30);
                        wr_store = (r_pc < CW'(Max));
                        n_dc     = r_dc + 2'd1;
                        n_ads    = 1'b1;
                    end else if (c == 8'h3F) begin
                        n_dc  = 2'd0;
                        n_ads = 1'b0;
                    end else if (c == 8'h3B) begin
                        if (!r_ads) n_fpi = 1'b1;
                        if (r_pc < CW'(Max)) n_pc = r_pc + CW'(1);
                        n_dc  = 2'd0;
                        n_ads = 1'b0;
                    end else begin
                        n_pc    = p;
                        n_phase = PH_TEXT;
                        unique case (c)
                            8'h48, 8'h66: begin
                                if (p == CW'(0)) begin
                                    n_col = 8'd1;
                                    n_row = 8'd1;
                                end else if (p == CW'(1)) begin
                                    n_col = 8'd1;
                                    n_row = aetp_pkg::clamp_lim(a, mr);
                                end else if (r_fpi) begin
                                    n_col = aetp_pkg::clamp_lim(s1, mc);
                                    n_row = aetp_pkg::clamp_lim(r_row, mr);
                                end else begin
                                    n_col = aetp_pkg::clamp_lim(s1, mc);
                                    n_row = aetp_pkg::clamp_lim(a, mr);
                                end
                                if (p < CW'(2)) n_col = aetp_pkg::clamp_lim(n_col, mc);
                            end
                            8'h41: begin
                                if (p == CW'(0)) begin
                                    if (r_row > 8'd1) n_row = r_row - 8'd1;
                                end else if (a >= r_row) n_row = 8'd1;
                                else n_row = r_row - a;
                            end
                            8'h42: begin
                                if (p == CW'(0)) begin
                                    if (r_row < mr) n_row = r_row + 8'd1;
                                end else if (r_row >= mr) n_row = mr;
                                else if (a > mr - r_row) n_row = mr;
                                else n_row = r_row + a;
                            end
                            8'h43: begin
                                if (p == CW'(0)) begin
                                    if (r_col < mc) n_col = r_col + 8'd1;
                                end else if (r_col >= mc) n_col = mc;
                                else if (a > mc - r_col) n_col = mc;
                                else n_col = r_col + a;
                            end
                            8'h44: begin
                                if (p == CW'(0)) begin
                                    if (r_col > 8'd1) n_col = r_col - 8'd1;
                                end else if (a >= r_col) n_col = 8'd1;
                                else n_col = r_col - a;
                            end
                            8'h73: begin
                                n_scol = r_col;
                                n_srow = r_row;
                            end
                            8'h75: begin
                                n_col = r_scol;
                                n_row = r_srow;
                            end
                            8'h4A: begin
                                emit     = (a == 8'd2);
                                emit_cmd = aetp_pkg::CMD_CLEAR_SCR;
                            end
                            8'h4B: begin
                                emit     = 1'b1;
                                emit_cmd = aetp_pkg::CMD_CLEAR_EOL;
                            end
                            8'h6D: begin
                                if (p == CW'(0)) sgr_ctrl.defaults = 1'b1;
                                else sgr_ctrl.start = 1'b1;
                                n_st = ST_WALK;
                            end
                            8'h6C: if (a == 8'd7) n_wrap = 1'b0;
                            8'h68: if (a == 8'd7) n_wrap = 1'b1;
                            default: ;
                        endcase
                    end
                end
                default: begin
                    if (c == 8'h1B) begin
                        n_phase   = PH_BRACKET;
                        clr_store = 1'b1;
                        n_pc      = '0;
                        n_dc      = 2'd0;
                        n_ads     = 1'b0;
                        n_fpi     = 1'b0;
                    end else begin
                        emit      = 1'b1;
                        emit_char = c;
                        // advance the cursor, wrapping at the right edge when wrap is on
                        if (r_col < mc) n_col = r_col + 8'd1;
                        else if (r_wrap) begin
                            n_col = 8'd1;
                            if (r_row < mr) n_row = r_row + 8'd1;
                        end
                    end
                end
            endcase
        end
    end

    // Control and cursor state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols  <= aetp_pkg::ResetColumns;
            r_rows  <= aetp_pkg::ResetRows;
            r_phase <= PH_TEXT;
            r_st    <= ST_IDLE;
            r_pc    <= '0;
            r_dc    <= 2'd0;
            r_ads   <= 1'b0;
            r_fpi   <= 1'b0;
            r_col   <= 8'd1;
            r_row   <= 8'd1;
            r_scol  <= 8'd1;
            r_srow  <= 8'd1;
            r_wrap  <= 1'b1;
            r_ov    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == aetp_pkg::CFG_COLUMNS) r_cols <= i_cfg_data;
                else r_rows <= i_cfg_data;
            end
            r_phase <= n_phase;
            r_st    <= n_st;
            r_pc    <= n_pc;
            r_dc    <= n_dc;
            r_ads   <= n_ads;
            r_fpi   <= n_fpi;
            r_col   <= n_col;
            r_row   <= n_row;
            r_scol  <= n_scol;
            r_srow  <= n_srow;
            r_wrap  <= n_wrap;
            if (emit) r_ov <= 1'b1;
            else if (o_cmd.ready) r_ov <= 1'b0;
        end
    end

    // Parameter store, cleared at each escape
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clr_store) begin
            for (int i = 0; i < Max; i++) r_store[i] <= 8'd0;
        end else if (wr_store) begin
            r_store[r_pc[aetp_pkg::IdxW-1:0]] <= n_acc;
        end
    end

    // Output stage payload, captured before the cursor moves
    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        if (emit) begin
            r_ocmd  <= emit_cmd;
            r_ochar <= emit_char;
            r_ocol  <= r_col;
            r_orow  <= r_row;
            r_ofg   <= sgr_stat.fg;
            r_obg   <= sgr_stat.bg;
        end
    end

    assign o_cmd.valid      = r_ov;
    assign o_cmd.command    = r_ocmd;
    assign o_cmd.char_code  = r_ochar;
    assign o_cmd.column     = r_ocol;
    assign o_cmd.row        = r_orow;
    assign o_cmd.foreground = r_ofg;
    assign o_cmd.background = r_obg;

    a_walk_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_WALK) |-> !r_ov)
        else $error("command pending during colour walk");
    a_busy_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sgr_stat.busy |-> (r_st == ST_WALK))
        else $error("colour unit busy outside walk");
    a_cursor_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col != 8'd0) && (r_row != 8'd0))
        else $error("cursor at zero coordinate");
    a_emit_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> !i_byte.ready)
        else $error("input taken while command pending");

endmodule

// ===== hw/rtl/aetp_sgr_unit.sv =====
module aetp_sgr_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  aetp_pkg::t_sgr_ctrl i_ctrl,
    input  logic [7:0]          i_value,
    output aetp_pkg::t_sgr_stat o_stat
);

    logic [4:0]                r_fg, n_fg;
    logic [2:0]                r_bg, n_bg;
    logic [4:0]                r_io, n_io;
    logic [aetp_pkg::IdxW-1:0] r_idx, n_idx;
    logic [aetp_pkg::CntW-1:0] r_last, n_last;
    logic                      r_busy, n_busy;

    // Apply one attribute parameter per cycle
    always_comb begin
        n_fg   = r_fg;
        n_bg   = r_bg;
        n_io   = r_io;
        n_idx  = r_idx;
        n_last = r_last;
        n_busy = r_busy;
        if (i_ctrl.defaults) begin
            n_fg = aetp_pkg::DefaultFg;
            n_bg = aetp_pkg::DefaultBg;
            n_io = 5'd0;
        end else if (i_ctrl.start) begin
            n_idx  = '0;
            n_last = i_ctrl.count - aetp_pkg::CntW'(1);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (i_value == 8'd0) begin
                n_fg = aetp_pkg::DefaultFg;
                n_bg = aetp_pkg::DefaultBg;
                n_io = 5'd0;
            end else if (i_value == 8'd1) begin
                if (r_io == 5'd0 || r_io == 5'd16) begin
                    n_fg = r_fg + 5'd8;
                    n_io = r_io + 5'd8;
                end
            end else if (i_value == 8'd5) begin
                if (r_fg < 5'd16) begin
                    n_fg = r_fg + 5'd16;
                    n_io = r_io + 5'd16;
                end
            end else if (i_value >= 8'd30 && i_value <= 8'd37) begin
                n_fg = r_io + {2'b00, aetp_pkg::dos_map(3'(i_value - 8'd30))};
            end else if (i_value >= 8'd40 && i_value <= 8'd47) begin
                n_bg = aetp_pkg::dos_map(3'(i_value - 8'd40));
            end
            if (aetp_pkg::CntW'(r_idx) == r_last) n_busy = 1'b0;
            else n_idx = r_idx + aetp_pkg::IdxW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg   <= aetp_pkg::DefaultFg;
            r_bg   <= aetp_pkg::DefaultBg;
            r_io   <= 5'd0;
            r_busy <= 1'b0;
            r_idx  <= '0;
            r_last <= '0;
        end else begin
            r_fg   <= n_fg;
            r_bg   <= n_bg;
            r_io   <= n_io;
            r_busy <= n_busy;
            r_idx  <= n_idx;
            r_last <= n_last;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.idx  = r_idx;
    assign o_stat.fg   = r_fg;
    assign o_stat.bg   = r_bg;

    // Walk index never passes the last parameter
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> aetp_pkg::CntW'(r_idx) <= r_last)
        else $error("colour walk index past last parameter");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.start && !i_ctrl.defaults) |=> r_busy)
        else $error("colour walk did not start");
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_ctrl.start)
        else $error("colour walk restarted while busy");

endmodule
